FILE: hw/rtl/aagol_pkg.sv
package aagol_pkg;

	// Field and state widths
	localparam int DW      = 32;   // sample, target and parameter width
	localparam int FRAC    = 16;   // fraction bits of the fixed-point format
	localparam int GSW     = 48;   // gain gradient sum width
	localparam int OSW     = 40;   // offset gradient sum width
	localparam int MSW     = 16;   // max_step width
	localparam int ELW     = 8;    // epoch_length width
	localparam int NUMW    = 40;   // normalized magnitude width
	localparam int DENW    = 32;   // normalized average width
	localparam int DVD_W   = 58;   // divider dividend / quotient width
	localparam int DVS_W   = 36;   // divider divisor width
	localparam int DIV_CW  = 6;    // divider iteration counter width
	localparam int SHW     = 5;    // normalize shift width
	localparam int AVG_DIV = 1000; // decay divisor of the running average

	// Average decay: x/1000 = (x>>3)/125, and for n < 2^45
	// floor(n/125) = (n * ceil(2^51/125)) >> 51
	localparam int         AVG_PRE = 3;               // 1000 = 8 * 125
	localparam int         RN_W    = 45;              // pre-shifted difference width
	localparam int         RCP_SH  = 51;              // reciprocal shift
	localparam int         RSUM_W  = 90;              // full reciprocal product width
	localparam logic [12:0] RCP_M1 = 13'h1062;        // reciprocal, upper bits
	localparam logic [31:0] RCP_M0 = 32'h4DD2_F1AA;   // reciprocal, lower 32 bits

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_MAX_STEP   = 1'b0,
		REG_EPOCH_LEN  = 1'b1
	} reg_idx_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MAP,
		ST_MUL2,
		ST_ACC,
		ST_AVG_GO,
		ST_AVG_MUL1,
		ST_AVG_MUL2,
		ST_AVG_UPD,
		ST_NORM,
		ST_UMUL,
		ST_STEP_GO,
		ST_STEP_WAIT,
		ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture the input transaction
		logic mul1;     // gain * sample
		logic map;      // mapped value and error
		logic mul2;     // sample * error
		logic acc;      // gradient sums and epoch count
		logic avg_go;   // size/diff capture
		logic rcp1;     // reciprocal partial products, low and high
		logic rcp2;     // reciprocal partial products, cross terms
		logic avg_upd;  // running average update
		logic norm;     // normalize numerator and denominator
		logic umul;     // max_step * 3 * num
		logic step_go;  // start step division
		logic apply;    // move the parameter
		logic psel;     // 0 gain, 1 offset
		logic out_load; // load the result register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic train;
		logic epoch_end;
		logic div_done;
	} sts_t;

	// Magnitude of a signed word, as unsigned of the same width
	function automatic logic [DW-1:0] mag32(input logic [DW-1:0] v);
		mag32 = v[DW-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

FILE: hw/rtl/adaptive_affine_gain_offset_learner.sv
// Online gain/offset learner in signed Q16.16: every transaction returns
// gain*x+offset and, for a train transaction, the fit error; after epoch_length
// train transactions gain and then offset each take a bounded step. One
// transaction is worked at a time; at the close of an epoch the restoring
// divider forms each step (one 58-bit division per parameter), and the
// running-average decay is a reciprocal multiply per parameter. A result
// waiting on the output does not hold up the next input; a second result
// waits in the final state until the first is taken.
module adaptive_affine_gain_offset_learner (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // sample_in[31:0], target_value[63:32]
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // mapped_out, fit_error, gain_now, offset_now
	input  logic         cfg_we,
	input  logic [0:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata
);

	aagol_pkg::cmd_t cmd;
	aagol_pkg::sts_t sts;

	aagol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aagol_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (s_tuser),
		.sample_in    (s_tdata[31:0]),
		.target_value (s_tdata[63:32]),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.result       (m_tdata)
	);

	// One transaction in flight: input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a transaction is in flight");

	// A result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// Divider completion is always consumed
	a_div_used: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> cmd.apply)
		else $error("divider result dropped");

endmodule

FILE: hw/rtl/aagol_div.sv
module aagol_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [aagol_pkg::DVD_W-1:0]    dividend,
	input  logic [aagol_pkg::DVS_W-1:0]    divisor,
	output logic                           done,
	output logic [aagol_pkg::DVD_W-1:0]    quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [aagol_pkg::DIV_CW-1:0]  cnt_q;
	logic [aagol_pkg::DVD_W-1:0]   quo_q;
	logic [aagol_pkg::DVS_W-1:0]   rem_q;
	logic [aagol_pkg::DVS_W-1:0]   dvs_q;
	logic [aagol_pkg::DVS_W:0]     trial;
	logic                          fit;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[aagol_pkg::DVD_W-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == aagol_pkg::DIV_CW'(aagol_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? aagol_pkg::DVS_W'(trial - {1'b0, dvs_q})
			             : trial[aagol_pkg::DVS_W-1:0];
			quo_q <= {quo_q[aagol_pkg::DVD_W-2:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/aagol_dp.sv
module aagol_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aagol_pkg::cmd_t               cmd,
	output aagol_pkg::sts_t               sts,
	input  logic                          req_type,
	input  logic signed [aagol_pkg::DW-1:0] sample_in,
	input  logic signed [aagol_pkg::DW-1:0] target_value,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_addr,
	input  logic [aagol_pkg::MSW-1:0]     cfg_wdata,
	output logic [4*aagol_pkg::DW-1:0]    result
);

	localparam int DW = aagol_pkg::DW;

	// Configuration
	logic [aagol_pkg::MSW-1:0] max_step_q;
	logic [aagol_pkg::ELW-1:0] epoch_len_q;

	// Learned state
	logic signed [DW-1:0]            gain_q, offset_q;
	logic signed [aagol_pkg::GSW-1:0] gsum_q;
	logic signed [aagol_pkg::OSW-1:0] osum_q;
	logic [aagol_pkg::GSW-1:0]       gavg_q;
	logic [aagol_pkg::OSW-1:0]       oavg_q;
	logic [aagol_pkg::ELW-1:0]       cnt_q;

	// Item registers
	logic                 train_q;
	logic signed [DW-1:0] x_q, t_q, y_q, err_q;
	logic [2*DW-1:0]      prod_q;
	logic                 neg_q;

	// Update registers
	logic [aagol_pkg::GSW-1:0]  size_q;
	logic                       ge_q;
	logic [aagol_pkg::NUMW-1:0] num_q;
	logic [aagol_pkg::DENW-1:0] den_q;
	logic                       avg_zero_q, big_q;
	logic [aagol_pkg::DVD_W-1:0] numer_q;
	logic [aagol_pkg::DVS_W-1:0] den10_q;

	// Average decay by reciprocal multiplication
	logic [aagol_pkg::RN_W-1:0]   rn_q;
	logic [2*DW-1:0]              rlo_q;
	logic [25:0]                  rhh_q;
	logic [45:0]                  rmid_q;
	logic [aagol_pkg::RSUM_W-1:0] rsum;
	logic [aagol_pkg::GSW-1:0]    avg_quo;

	// Divider
	logic                        div_start, div_done;
	logic [aagol_pkg::DVD_W-1:0] div_dvd, div_quo;
	logic [aagol_pkg::DVS_W-1:0] div_dvs;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q  <= aagol_pkg::MSW'(328);
			epoch_len_q <= aagol_pkg::ELW'(20);
		end else if (cfg_we) begin
			unique case (aagol_pkg::reg_idx_t'(cfg_addr))
				aagol_pkg::REG_MAX_STEP:  max_step_q  <= cfg_wdata;
				aagol_pkg::REG_EPOCH_LEN: epoch_len_q <= cfg_wdata[aagol_pkg::ELW-1:0];
				default: ;
			endcase
		end
	end

	// Shared 32x32 magnitude multiplier
	logic [DW-1:0] mul_a, mul_b;
	always_comb begin
		if (cmd.mul1) begin
			mul_a = aagol_pkg::mag32(gain_q);
			mul_b = aagol_pkg::mag32(x_q);
		end else begin
			mul_a = aagol_pkg::mag32(x_q);
			mul_b = aagol_pkg::mag32(err_q);
		end
	end

	// Mapped value: truncated product, saturated, plus offset; then the saturated fit error
	logic [47:0]          tr;
	logic [DW-1:0]        m_lim;
	logic signed [DW+1:0] prodv;
	logic signed [DW+2:0] ysum;
	logic signed [DW-1:0] y_c;
	logic signed [DW:0]   ediff;
	logic signed [DW-1:0] e_c;
	always_comb begin
		tr = prod_q[2*DW-1:aagol_pkg::FRAC];
		if (neg_q)
			m_lim = (tr > 48'h8000_0000) ? 32'h8000_0000 : tr[DW-1:0];
		else
			m_lim = (tr > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : tr[DW-1:0];
		prodv = neg_q ? -$signed({2'b00, m_lim}) : $signed({2'b00, m_lim});
		ysum  = (DW+3)'(prodv) + (DW+3)'(offset_q);
		if (ysum > (DW+3)'(32'sh7FFF_FFFF))
			y_c = 32'sh7FFF_FFFF;
		else if (ysum < -(DW+3)'(64'sh8000_0000))
			y_c = 32'sh8000_0000;
		else
			y_c = ysum[DW-1:0];
		ediff = (DW+1)'(t_q) - (DW+1)'(y_c);
		if (ediff > (DW+1)'(32'sh7FFF_FFFF))
			e_c = 32'sh7FFF_FFFF;
		else if (ediff < -(DW+1)'(64'sh8000_0000))
			e_c = 32'sh8000_0000;
		else
			e_c = ediff[DW-1:0];
	end

	// Gradient accumulation, saturating
	logic signed [aagol_pkg::GSW:0] term, gnext;
	logic signed [aagol_pkg::OSW:0] onext;
	logic signed [aagol_pkg::GSW-1:0] gsat;
	logic signed [aagol_pkg::OSW-1:0] osat;
	logic [aagol_pkg::ELW-1:0] cnt_next;
	always_comb begin
		term  = neg_q ? -$signed({1'b0, tr}) : $signed({1'b0, tr});
		gnext = (aagol_pkg::GSW+1)'(gsum_q) + term;
		if (gnext[aagol_pkg::GSW] != gnext[aagol_pkg::GSW-1])
			gsat = gnext[aagol_pkg::GSW] ? {1'b1, {(aagol_pkg::GSW-1){1'b0}}}
			                             : {1'b0, {(aagol_pkg::GSW-1){1'b1}}};
		else
			gsat = gnext[aagol_pkg::GSW-1:0];
		onext = (aagol_pkg::OSW+1)'(osum_q) + (aagol_pkg::OSW+1)'(err_q);
		if (onext[aagol_pkg::OSW] != onext[aagol_pkg::OSW-1])
			osat = onext[aagol_pkg::OSW] ? {1'b1, {(aagol_pkg::OSW-1){1'b0}}}
			                             : {1'b0, {(aagol_pkg::OSW-1){1'b1}}};
		else
			osat = onext[aagol_pkg::OSW-1:0];
		cnt_next = cnt_q + 1'b1;
	end

	// Decay quotient from the registered partial products
	always_comb begin
		rsum = aagol_pkg::RSUM_W'(rlo_q) + (aagol_pkg::RSUM_W'(rmid_q) << 32)
		     + (aagol_pkg::RSUM_W'(rhh_q) << 64);
		avg_quo = aagol_pkg::GSW'(rsum[aagol_pkg::RSUM_W-1:aagol_pkg::RCP_SH]);
	end

	// Selected parameter for the epoch update
	logic signed [aagol_pkg::GSW-1:0] sum_sel;
	logic [aagol_pkg::GSW-1:0]        avg_sel, size_c, diff_c, avg_new;
	logic signed [DW-1:0]             par_sel;
	always_comb begin
		sum_sel = cmd.psel ? aagol_pkg::GSW'(osum_q) : gsum_q;
		avg_sel = cmd.psel ? aagol_pkg::GSW'(oavg_q) : gavg_q;
		par_sel = cmd.psel ? offset_q : gain_q;
		size_c  = sum_sel[aagol_pkg::GSW-1] ? aagol_pkg::GSW'(-sum_sel) : sum_sel;
		diff_c  = (size_c >= avg_sel) ? size_c - avg_sel : avg_sel - size_c;
		avg_new = ge_q ? avg_sel + avg_quo : avg_sel - avg_quo;
	end

	// Normalize so the average fits in 32 bits
	logic [aagol_pkg::SHW-1:0]  sh;
	logic [aagol_pkg::GSW-1:0]  num_sh, den_sh;
	always_comb begin
		sh = '0;
		for (int i = 0; i < aagol_pkg::GSW - aagol_pkg::DENW; i++)
			if (avg_sel[aagol_pkg::DENW + i])
				sh = aagol_pkg::SHW'(i + 1);
		num_sh = size_q >> sh;
		den_sh = avg_sel >> sh;
	end

	// Step and new parameter
	logic [aagol_pkg::MSW-1:0] step;
	logic signed [DW+1:0]      pnext;
	logic signed [DW-1:0]      psat;
	always_comb begin
		if (avg_zero_q || big_q || div_quo > aagol_pkg::DVD_W'(max_step_q))
			step = max_step_q;
		else
			step = div_quo[aagol_pkg::MSW-1:0];
		if (sum_sel[aagol_pkg::GSW-1])
			pnext = (DW+2)'(par_sel) - (DW+2)'({1'b0, step});
		else
			pnext = (DW+2)'(par_sel) + (DW+2)'({1'b0, step});
		if (pnext > (DW+2)'(32'sh7FFF_FFFF))
			psat = 32'sh7FFF_FFFF;
		else if (pnext < -(DW+2)'(64'sh8000_0000))
			psat = 32'sh8000_0000;
		else
			psat = pnext[DW-1:0];
	end

	// Divider operands: step division only
	assign div_start = cmd.step_go;
	assign div_dvd   = numer_q;
	assign div_dvs   = den10_q;

	aagol_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Learned state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			offset_q <= '0;
			gsum_q   <= '0;
			osum_q   <= '0;
			gavg_q   <= '0;
			oavg_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd.acc) begin
				gsum_q <= gsat;
				osum_q <= osat;
				cnt_q  <= (cnt_next >= epoch_len_q) ? '0 : cnt_next;
			end
			if (cmd.avg_upd) begin
				if (cmd.psel)
					oavg_q <= avg_new[aagol_pkg::OSW-1:0];
				else
					gavg_q <= avg_new;
			end
			if (cmd.apply && size_q != '0) begin
				if (cmd.psel) begin
					offset_q <= psat;
					osum_q   <= '0;
				end else begin
					gain_q <= psat;
					gsum_q <= '0;
				end
			end
		end
	end

	// Item and update working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			train_q <= req_type;
			x_q     <= sample_in;
			t_q     <= target_value;
		end
		if (cmd.mul1 || cmd.mul2) begin
			prod_q <= mul_a * mul_b;
			neg_q  <= cmd.mul1 ? (gain_q[DW-1] ^ x_q[DW-1]) : (x_q[DW-1] ^ err_q[DW-1]);
		end
		if (cmd.map) begin
			y_q   <= y_c;
			err_q <= train_q ? e_c : '0;
		end
		if (cmd.avg_go) begin
			size_q <= size_c;
			ge_q   <= size_c >= avg_sel;
			rn_q   <= diff_c[aagol_pkg::GSW-1:aagol_pkg::AVG_PRE];
		end
		// Reciprocal multiply split into partial products: low and high on rcp1, cross terms on rcp2
		if (cmd.rcp1) begin
			rlo_q <= rn_q[DW-1:0] * aagol_pkg::RCP_M0;
			rhh_q <= rn_q[aagol_pkg::RN_W-1:DW] * aagol_pkg::RCP_M1;
		end
		if (cmd.rcp2)
			rmid_q <= rn_q[DW-1:0] * aagol_pkg::RCP_M1
			        + rn_q[aagol_pkg::RN_W-1:DW] * aagol_pkg::RCP_M0;
		if (cmd.norm) begin
			num_q      <= num_sh[aagol_pkg::NUMW-1:0];
			den_q      <= den_sh[aagol_pkg::DENW-1:0];
			avg_zero_q <= avg_sel == '0;
			big_q      <= |num_sh[aagol_pkg::GSW-1:aagol_pkg::NUMW];
		end
		if (cmd.umul) begin
			numer_q <= (aagol_pkg::DVD_W'(max_step_q) * aagol_pkg::DVD_W'(3))
			         * aagol_pkg::DVD_W'(num_q);
			den10_q <= (aagol_pkg::DVS_W'(den_q) << 3) + (aagol_pkg::DVS_W'(den_q) << 1);
		end
		if (cmd.out_load)
			result <= {offset_q, gain_q, err_q, y_q};
	end

	assign sts.train     = train_q;
	assign sts.epoch_end = cnt_next >= epoch_len_q;
	assign sts.div_done  = div_done;

endmodule

FILE: hw/rtl/aagol_ctrl.sv
module aagol_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  aagol_pkg::sts_t  sts,
	output aagol_pkg::cmd_t  cmd
);

	aagol_pkg::state_t state_q, state_d;
	logic              psel_q, psel_d;
	logic              ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= aagol_pkg::ST_IDLE;
			psel_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			psel_q  <= psel_d;
			if (cmd.out_load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		psel_d   = psel_q;
		cmd      = '0;
		cmd.psel = psel_q;
		in_ready = 1'b0;
		unique case (state_q)
			aagol_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = aagol_pkg::ST_MUL1;
				end
			end
			aagol_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = aagol_pkg::ST_MAP;
			end
			aagol_pkg::ST_MAP: begin
				cmd.map = 1'b1;
				state_d = sts.train ? aagol_pkg::ST_MUL2 : aagol_pkg::ST_OUT;
			end
			aagol_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = aagol_pkg::ST_ACC;
			end
			aagol_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				psel_d  = 1'b0;
				state_d = sts.epoch_end ? aagol_pkg::ST_AVG_GO : aagol_pkg::ST_OUT;
			end
			aagol_pkg::ST_AVG_GO: begin
				cmd.avg_go = 1'b1;
				state_d    = aagol_pkg::ST_AVG_MUL1;
			end
			aagol_pkg::ST_AVG_MUL1: begin
				cmd.rcp1 = 1'b1;
				state_d  = aagol_pkg::ST_AVG_MUL2;
			end
			aagol_pkg::ST_AVG_MUL2: begin
				cmd.rcp2 = 1'b1;
				state_d  = aagol_pkg::ST_AVG_UPD;
			end
			aagol_pkg::ST_AVG_UPD: begin
				cmd.avg_upd = 1'b1;
				state_d     = aagol_pkg::ST_NORM;
			end
			aagol_pkg::ST_NORM: begin
				cmd.norm = 1'b1;
				state_d  = aagol_pkg::ST_UMUL;
			end
			aagol_pkg::ST_UMUL: begin
				cmd.umul = 1'b1;
				state_d  = aagol_pkg::ST_STEP_GO;
			end
			aagol_pkg::ST_STEP_GO: begin
				cmd.step_go = 1'b1;
				state_d     = aagol_pkg::ST_STEP_WAIT;
			end
			aagol_pkg::ST_STEP_WAIT: begin
				if (sts.div_done) begin
					cmd.apply = 1'b1;
					if (psel_q) begin
						state_d = aagol_pkg::ST_OUT;
					end else begin
						psel_d  = 1'b1;
						state_d = aagol_pkg::ST_AVG_GO;
					end
				end
			end
			aagol_pkg::ST_OUT: begin
				if (!ovalid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = aagol_pkg::ST_IDLE;
				end
			end
			default: state_d = aagol_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = ovalid_q;

endmodule

FILE: tb/aagol_checker.sv
module aagol_checker
	import aagol_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [63:0]  s_tdata,   // sample_in[31:0], target_value[63:32]
	input  logic         s_tuser,   // req_type
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,   // mapped_out, fit_error, gain_now, offset_now
	input  logic         cfg_we,
	input  logic [0:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata,
	output int           fail_count,
	output int           pending
);

	typedef struct {
		logic [DW-1:0] mapped;
		logic [DW-1:0] err;
		logic [DW-1:0] gain;
		logic [DW-1:0] ofs;
	} learner_result_t;

	learner_result_t result_q[$];

	// Shadow of the learner state and registers
	longint      gain_r, ofs_r, gsum_r, osum_r;
	logic [63:0] gavg_r, oavg_r;
	logic [63:0] step_max;
	logic [7:0]  epoch_len, epoch_cnt;

	assign pending = result_q.size();

	function automatic longint sat_to(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// Fixed-point multiply: magnitude truncated, then saturated to w bits
	function automatic longint fx_mul(longint a, longint b, int w);
		logic [63:0] ua, ub, m, lim;
		logic        neg;
		ua  = a < 0 ? 64'(-a) : 64'(a);
		ub  = b < 0 ? 64'(-b) : 64'(b);
		neg = (a < 0) != (b < 0);
		m   = (ua * ub) >> FRAC;
		lim = 64'd1 << (w - 1);
		if (!neg)
			lim = lim - 1;
		if (m > lim)
			m = lim;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// End-of-epoch move of one parameter
	function automatic void move_param(inout longint param, inout longint sum,
			inout logic [63:0] avg);
		logic [63:0] size, num, den, stp;
		size = sum < 0 ? 64'(-sum) : 64'(sum);
		if (size >= avg)
			avg = avg + (size - avg) / AVG_DIV;
		else
			avg = avg - (avg - size) / AVG_DIV;
		if (sum == 0)
			return;
		if (avg == 0) begin
			stp = step_max;
		end else begin
			num = size;
			den = avg;
			while ((den >> 32) != 0) begin
				den = den >> 1;
				num = num >> 1;
			end
			if ((num >> 40) != 0) begin
				stp = step_max;
			end else begin
				stp = (step_max * 3 * num) / (10 * den);
				if (stp > step_max)
					stp = step_max;
			end
		end
		param = sat_to(sum > 0 ? param + longint'(stp) : param - longint'(stp), DW);
		sum = 0;
	endfunction

	function automatic learner_result_t predict_learner(logic train, logic [31:0] xs,
			logic [31:0] ts);
		learner_result_t r;
		longint x, t, y, e;
		x = longint'(signed'(xs));
		t = longint'(signed'(ts));
		y = sat_to(fx_mul(gain_r, x, DW) + ofs_r, DW);
		e = 0;
		if (train) begin
			e = sat_to(t - y, DW);
			gsum_r = sat_to(gsum_r + fx_mul(x, e, GSW), GSW);
			osum_r = sat_to(osum_r + e, OSW);
			epoch_cnt = epoch_cnt + 1;
			if (epoch_cnt >= epoch_len) begin
				move_param(gain_r, gsum_r, gavg_r);
				move_param(ofs_r, osum_r, oavg_r);
				epoch_cnt = 0;
			end
		end
		r.mapped = y[DW-1:0];
		r.err    = e[DW-1:0];
		r.gain   = gain_r[DW-1:0];
		r.ofs    = ofs_r[DW-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Monitor: results first, then new transactions and register writes
	always @(posedge clk or negedge arst_n) begin
		learner_result_t exp_r;
		if (!arst_n) begin
			gain_r     <= 0;
			ofs_r      <= 0;
			gsum_r     <= 0;
			osum_r     <= 0;
			gavg_r     <= 0;
			oavg_r     <= 0;
			epoch_cnt  <= 0;
			step_max   <= 64'd328;
			epoch_len  <= 8'd20;
			fail_count <= 0;
			result_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h",
						$time, m_tdata);
					fail_count++;
				end else begin
					exp_r = result_q.pop_front();
					check_field("mapped_out", exp_r.mapped, m_tdata[31:0]);
					check_field("fit_error", exp_r.err, m_tdata[63:32]);
					check_field("gain_now", exp_r.gain, m_tdata[95:64]);
					check_field("offset_now", exp_r.ofs, m_tdata[127:96]);
				end
			end
			if (s_tvalid && s_tready)
				result_q.push_back(predict_learner(s_tuser, s_tdata[31:0], s_tdata[63:32]));
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_MAX_STEP:  step_max = 64'(cfg_wdata);
					REG_EPOCH_LEN: epoch_len = cfg_wdata[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: tb/adaptive_affine_gain_offset_learner_tb.sv
module adaptive_affine_gain_offset_learner_tb;
	import aagol_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 155;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         cfg_we;
	logic [0:0]   cfg_addr;
	logic [15:0]  cfg_wdata;
	int           fail_count;
	int           pending;
	int           idle_mode;
	int           quiet_cycles;

	adaptive_affine_gain_offset_learner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	aagol_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle modes: 0 none, 1 sender, 2 receiver, 3 both
	always @(posedge clk) begin
		if (idle_mode == 2)
			m_tready <= ($urandom_range(99) >= 51);
		else if (idle_mode == 3)
			m_tready <= ($urandom_range(99) >= 36);
		else
			m_tready <= 1'b1;
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_item(logic train, logic [31:0] x, logic [31:0] t);
		int gap_pct;
		gap_pct = idle_mode == 1 ? 51 : (idle_mode == 3 ? 36 : 0);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= train;
		s_tdata  <= {t, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Hold off until every result is back, then let the block settle
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// One write cycle, then one quiet cycle
	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly a noisy linear target so the parameters learn, plus raw noise
	task automatic send_random;
		int          pick;
		logic [31:0] x, t;
		pick = $urandom_range(99);
		x = 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
		t = x + {x[31], x[31:1]} + 32'h0000_4000 + 32'($urandom_range(4095)) - 32'd2048;
		if (pick < 70)
			send_item(1'b1, x, t);
		else if (pick < 85)
			send_item(1'b0, x, $urandom);
		else
			send_item(1'($urandom_range(1)), $urandom, $urandom);
	endtask

	logic [15:0] step_set[8] = '{16'd65535, 16'd1, 16'd0, 16'd328,
		16'd4000, 16'd65535, 16'd100, 16'd20000};
	logic [15:0] len_set[8]  = '{16'd1, 16'd255, 16'd3, 16'd0,
		16'd5, 16'd255, 16'd2, 16'd10};

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b1;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		idle_mode = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes at reset settings, enough trains to close an epoch
		send_item(1'b0, 32'h7fff_ffff, 32'h0);
		send_item(1'b0, 32'h8000_0000, 32'hffff_ffff);
		send_item(1'b1, 32'h7fff_ffff, 32'h8000_0000);
		send_item(1'b1, 32'h8000_0000, 32'h7fff_ffff);
		send_item(1'b1, 32'h0, 32'h0);
		send_item(1'b1, 32'hffff_ffff, 32'h0000_0001);
		for (int i = 0; i < 16; i++)
			send_item(1'b1, 32'h0001_0000 + 32'(i << 12), 32'h0002_0000);
		send_item(1'b0, 32'h0001_0000, 32'h0);
		drain();

		// Zero sums: a zero sample leaves the gain sum at zero, so gain stays where it is
		write_reg(REG_EPOCH_LEN, 16'd1);
		write_reg(REG_MAX_STEP, 16'd65535);
		send_item(1'b1, 32'h0, 32'h0);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_reg(REG_MAX_STEP, step_set[p]);
			write_reg(REG_EPOCH_LEN, len_set[p]);
			idle_mode = p % 4;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random();
			// Lower the epoch length mid-epoch on one phase
			if (p == 5) begin
				drain();
				write_reg(REG_EPOCH_LEN, 16'd3);
				for (int i = 0; i < 20; i++)
					send_random();
			end
			drain();
		end

		idle_mode = 0;
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/aagol_pkg.sv
hw/rtl/aagol_div.sv
hw/rtl/aagol_dp.sv
hw/rtl/aagol_ctrl.sv
hw/rtl/adaptive_affine_gain_offset_learner.sv
tb/aagol_checker.sv
tb/adaptive_affine_gain_offset_learner_tb.sv
